/* hdl/erb_pkg.sv */
// Package for the escape-filtering ring buffer.
// Holds command codes, filter constants and the queue entry type.
// No dependencies.
package erb_pkg;

  localparam int CMD_W = 2;
  localparam int LEN_W = 16;
  localparam int BYTE_W = 8;
  localparam int CFG_W = 11;
  localparam int OCC_W = 10;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [BYTE_W-1:0] CHAR_ESC = 8'h1b;
  localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0d;
  localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;

  // Operations handed from the front to the back.
  typedef enum logic [2:0] {
    OP_STORE = 3'd0,  // accepted push, byte written
    OP_ACK   = 3'd1,  // accepted push, byte filtered out
    OP_NOP   = 3'd2,  // refused push or unknown command
    OP_POP   = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
  } q_entry_t;

endpackage

/* hdl/erb_ifs.sv */
// Channel interfaces for the escape-filtering ring buffer.
// Depends on erb_pkg for field widths.
interface erb_in_if;
  logic                          valid;
  logic                          ready;
  logic [erb_pkg::CMD_W-1:0]     command;
  logic [erb_pkg::LEN_W-1:0]     message_length;
  logic [erb_pkg::BYTE_W-1:0]    data_in;
  modport source (output valid, command, message_length, data_in, input ready);
  modport sink   (input valid, command, message_length, data_in, output ready);
endinterface

interface erb_out_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic [erb_pkg::BYTE_W-1:0]    data_out;
  logic [erb_pkg::OCC_W-1:0]     first_chunk;
  logic [erb_pkg::OCC_W-1:0]     residue;
  logic [erb_pkg::OCC_W-1:0]     occupied;
  logic                          empty_res;
  modport source (output valid, accepted, data_out, first_chunk, residue, occupied,
                  empty_res, input ready);
  modport sink   (input valid, accepted, data_out, first_chunk, residue, occupied,
                  empty_res, output ready);
endinterface

interface erb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [erb_pkg::CFG_W-1:0]     data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* hdl/erb_front.sv */
// Front end: accepts requests, checks length, runs the escape filter.
// Depends on erb_pkg and erb_in_if; feeds erb_queue.
module erb_front #(
  parameter int RW = 11
) (
  input  logic              clk,
  input  logic              rst,
  erb_in_if.sink            in_ch,
  input  logic [RW-1:0]     ring_size,
  output erb_pkg::q_entry_t q_entry,
  output logic              q_push,
  input  logic              q_ready
);
  import erb_pkg::*;

  localparam int LW = (RW > LEN_W) ? RW : LEN_W;

  logic in_escape;
  logic in_escape_next;
  logic len_ok;
  logic is_letter;
  op_t  op;

  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid && q_ready;
  assign len_ok      = LW'(in_ch.message_length) < LW'(ring_size);
  assign is_letter   = (in_ch.data_in >= 8'h61 && in_ch.data_in <= 8'h7a) ||
                       (in_ch.data_in >= 8'h41 && in_ch.data_in <= 8'h5a);

  always_comb begin
    op             = OP_NOP;
    in_escape_next = in_escape;
    unique case (in_ch.command)
      CMD_PUSH: begin
        if (len_ok) begin
          if (in_ch.data_in == CHAR_ESC) begin
            in_escape_next = 1'b1;
            op             = OP_ACK;
          end else if (in_escape) begin
            if (is_letter) in_escape_next = 1'b0;
            op = OP_ACK;
          end else if (in_ch.data_in == CHAR_CR || in_ch.data_in == CHAR_NUL) begin
            op = OP_ACK;
          end else begin
            op = OP_STORE;
          end
        end
      end
      CMD_POP:   op = OP_POP;
      CMD_CLEAR: op = OP_CLEAR;
      default:   op = OP_NOP;
    endcase
  end

  assign q_entry.op   = op;
  assign q_entry.data = in_ch.data_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_escape <= 1'b0;
    end else if (q_push) begin
      in_escape <= in_escape_next;
    end
  end

endmodule

/* hdl/erb_queue.sv */
// Two-entry queue between the front end and the ring engine.
// Depends on erb_pkg.
module erb_queue (
  input  logic              clk,
  input  logic              rst,
  input  erb_pkg::q_entry_t push_entry,
  input  logic              push,
  output logic              push_ready,
  output erb_pkg::q_entry_t pop_entry,
  output logic              pop_valid,
  input  logic              pop
);
  import erb_pkg::*;

  q_entry_t   slots [2];
  logic       wr_idx;
  logic       rd_idx;
  logic [1:0] count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_entry  = slots[rd_idx];

  always_ff @(posedge clk) begin
    if (push) slots[wr_idx] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= 1'b0;
      rd_idx <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_idx <= ~wr_idx;
      if (pop)  rd_idx <= ~rd_idx;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (rst) (count == 2'd0) |-> !pop)
    else $error("queue pop while empty");
  assert property (@(posedge clk) disable iff (rst) (count == 2'd2) |-> !push)
    else $error("queue push while full");

endmodule

/* hdl/erb_back.sv */
// Ring engine: byte store, read/write positions, occupancy report.
// Depends on erb_pkg and erb_out_if; fed by erb_queue.
module erb_back #(
  parameter int DEPTH = 1024,
  parameter int PW    = 10,
  parameter int RW    = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [RW-1:0]     ring_size,
  input  logic              cfg_wr,
  input  erb_pkg::q_entry_t q_entry,
  input  logic              q_valid,
  output logic              q_take,
  erb_out_if.source         out_ch
);
  import erb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_REPORT = 2'b10
  } state_t;

  state_t state;

  logic [BYTE_W-1:0] byte_store [DEPTH];
  logic [BYTE_W-1:0] rd_data;
  logic [PW-1:0]     wp;
  logic [PW-1:0]     rp;
  logic [PW-1:0]     wp_inc;
  logic [PW-1:0]     rp_inc;
  logic [RW-1:0]     wp_plus;
  logic [RW-1:0]     rp_plus;
  logic              acc;
  logic              pop_ok;
  logic              out_free;

  logic [RW-1:0]     first;
  logic [RW-1:0]     resid;
  logic [RW:0]       total;

  logic              out_valid;
  logic              out_acc;
  logic [BYTE_W-1:0] out_data;
  logic [OCC_W-1:0]  out_first;
  logic [OCC_W-1:0]  out_resid;
  logic [OCC_W-1:0]  out_occ;
  logic              out_empty;

  assign wp_plus  = RW'(wp) + RW'(1);
  assign rp_plus  = RW'(rp) + RW'(1);
  assign wp_inc   = (wp_plus < ring_size) ? PW'(wp_plus) : '0;
  assign rp_inc   = (rp_plus < ring_size) ? PW'(rp_plus) : '0;
  assign q_take   = (state == S_IDLE) && q_valid;
  assign out_free = !out_valid || out_ch.ready;

  always_comb begin
    first = '0;
    resid = '0;
    if (wp > rp) begin
      first = RW'(wp - rp);
    end else if (wp < rp) begin
      first = ring_size - RW'(rp);
      resid = RW'(wp);
    end
    total = (RW + 1)'(first) + (RW + 1)'(resid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      rp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_REPORT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_take) state <= S_REPORT;
        end
        S_REPORT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_wr) begin
        wp <= '0;
        rp <= '0;
      end else if (q_take) begin
        unique case (q_entry.op)
          OP_STORE: begin
            wp <= wp_inc;
            if (wp_inc == rp) rp <= rp_inc;
          end
          OP_POP: begin
            if (wp != rp) rp <= rp_inc;
          end
          OP_CLEAR: begin
            wp <= '0;
            rp <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      rd_data <= byte_store[rp];
      if (q_entry.op == OP_STORE) byte_store[wp] <= q_entry.data;
      acc    <= (q_entry.op == OP_STORE) || (q_entry.op == OP_ACK) ||
                (q_entry.op == OP_CLEAR) || (q_entry.op == OP_POP && wp != rp);
      pop_ok <= (q_entry.op == OP_POP) && (wp != rp);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_REPORT && out_free) begin
      out_acc   <= acc;
      out_data  <= pop_ok ? rd_data : '0;
      out_first <= OCC_W'(first);
      out_resid <= OCC_W'(resid);
      out_occ   <= OCC_W'(total);
      out_empty <= (wp == rp);
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.accepted    = out_acc;
  assign out_ch.data_out    = out_data;
  assign out_ch.first_chunk = out_first;
  assign out_ch.residue     = out_resid;
  assign out_ch.occupied    = out_occ;
  assign out_ch.empty_res   = out_empty;

  assert property (@(posedge clk) disable iff (rst) RW'(wp) < ring_size)
    else $error("write position beyond ring size");
  assert property (@(posedge clk) disable iff (rst) RW'(rp) < ring_size)
    else $error("read position beyond ring size");
  assert property (@(posedge clk) disable iff (rst)
    (q_take && q_entry.op == OP_POP && wp == rp) |=> (state == S_REPORT && !pop_ok && !acc))
    else $error("pop on empty ring reported a byte");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_REPORT && out_valid && !out_ch.ready) |=> (state == S_REPORT))
    else $error("report overwrote an untaken result");

endmodule

/* hdl/escape_filtering_overwrite_ring_buffer_unit.sv */
// Top level of the escape-filtering overwrite ring buffer.
// Depends on erb_pkg, erb_ifs, erb_front, erb_queue and erb_back.
//
// Byte ring for log text. Each request (push, pop, clear) yields exactly one
// result carrying the occupancy after the request. The front end accepts one
// request per cycle into a two-entry queue while the queue has room; the ring
// engine takes one request at a time, updating positions and accessing the
// byte store in its idle state, then loading the result register in its
// report state, where it waits while the previous result is still untaken.
// The size register may be written only while idle and resets both
// positions; there is no clearing pass after reset.
module escape_filtering_overwrite_ring_buffer_unit #(
  parameter int DEPTH = 1024
) (
  input  logic       clk,
  input  logic       rst,
  erb_in_if.sink     in_ch,
  erb_out_if.source  out_ch,
  erb_cfg_if.sink    cfg_ch
);
  import erb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW = $clog2(DEPTH + 1);
  localparam int RESET_SIZE = (DEPTH < 1024) ? DEPTH : 1024;

  logic [RW-1:0] ring_size;
  logic [RW-1:0] ring_size_next;
  logic          cfg_wr;
  logic [31:0]   cfg_val;

  q_entry_t      f_entry;
  logic          f_push;
  logic          f_ready;
  q_entry_t      b_entry;
  logic          b_valid;
  logic          b_take;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;
  assign cfg_val      = 32'(cfg_ch.data);

  always_comb begin
    if (cfg_val == 32'd0) begin
      ring_size_next = RW'(1);
    end else if (cfg_val > 32'(DEPTH)) begin
      ring_size_next = RW'(DEPTH);
    end else begin
      ring_size_next = RW'(cfg_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size <= RW'(RESET_SIZE);
    end else if (cfg_wr) begin
      ring_size <= ring_size_next;
    end
  end

  erb_front #(.RW(RW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .ring_size (ring_size),
    .q_entry   (f_entry),
    .q_push    (f_push),
    .q_ready   (f_ready)
  );

  erb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_entry (f_entry),
    .push       (f_push),
    .push_ready (f_ready),
    .pop_entry  (b_entry),
    .pop_valid  (b_valid),
    .pop        (b_take)
  );

  erb_back #(.DEPTH(DEPTH), .PW(PW), .RW(RW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .ring_size (ring_size),
    .cfg_wr    (cfg_wr),
    .q_entry   (b_entry),
    .q_valid   (b_valid),
    .q_take    (b_take),
    .out_ch    (out_ch)
  );

endmodule
